>>> design/bmg_pkg.sv
// shared types, constants and division helpers for the gaussian pair generator
`default_nettype none
package bmg_pkg;

   localparam int UNIFORM_BITS_DEF  = 32;
   localparam int OUT_FRAC_BITS_DEF = 11;
   localparam int FIELD_W           = 32;
   localparam int OUT_W             = 16;
   localparam int LOG_FRAC          = 24;
   localparam int TRIG_W            = 31;
   localparam int X2_W              = 32;
   localparam int HORNER_STEPS      = 6;
   localparam int RECIP_W           = 33;

   localparam logic [TRIG_W-1:0] Q30_ONE      = 31'h4000_0000;
   localparam logic [TRIG_W-1:0] TWO_LN2_Q30  = 31'd1488522236;
   localparam logic [TRIG_W-1:0] HALF_PI_Q30  = 31'd1686629713;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // ceil(2^(32+l)/d) with l = ceil(log2 d): exact floor division for 32-bit words
   localparam logic [RECIP_W-1:0] RECIP_156 = 33'(((65'd1 << 40) + 65'd155) / 65'd156);
   localparam logic [RECIP_W-1:0] RECIP_110 = 33'(((65'd1 << 39) + 65'd109) / 65'd110);
   localparam logic [RECIP_W-1:0] RECIP_72  = 33'(((65'd1 << 39) + 65'd71) / 65'd72);
   localparam logic [RECIP_W-1:0] RECIP_42  = 33'(((65'd1 << 38) + 65'd41) / 65'd42);
   localparam logic [RECIP_W-1:0] RECIP_20  = 33'(((65'd1 << 37) + 65'd19) / 65'd20);
   localparam logic [RECIP_W-1:0] RECIP_6   = 33'(((65'd1 << 35) + 65'd5) / 65'd6);

   typedef struct packed {
      logic [FIELD_W-1:0] uniform_radius;
      logic [FIELD_W-1:0] uniform_angle;
   } bmg_req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] normal_cos;
      logic signed [OUT_W-1:0] normal_sin;
   } bmg_rsp_type;

   function automatic logic [RECIP_W-1:0] horner_recip(input int idx);
      logic [RECIP_W-1:0] val;
      case (idx)
         0: val = RECIP_156;
         1: val = RECIP_110;
         2: val = RECIP_72;
         3: val = RECIP_42;
         4: val = RECIP_20;
         5: val = RECIP_6;
         default: val = '0;
      endcase
      return val;
   endfunction

   function automatic int horner_shift(input int idx);
      int val;
      case (idx)
         0: val = 40;
         1: val = 39;
         2: val = 39;
         3: val = 38;
         4: val = 37;
         5: val = 35;
         default: val = 0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

>>> design/box_muller_gaussian_pair.sv
// top level: pipelined box-muller transform, uniform pair in, gaussian pair out
`default_nettype none
// Box-Muller gaussian pair generator. A word is taken at every clock edge where
// start is high and busy is low; busy is high only during reset and until the
// first clock edge after it, so a new word may enter every cycle. Each word
// gives exactly one result word, shown on rsp_data for one cycle with rsp_strobe
// high. The receiver cannot hold results off and nothing in the pipe waits. The
// radius path is the longer one: one normalize stage, one squaring stage per log
// fraction bit (24), the log-to-radius scale, and one stage per bit of the square
// root (RAD_W, 28 at the default widths); the angle path (sin and cos by Horner
// series, one multiply per stage) runs beside it and is delayed to meet it.
module box_muller_gaussian_pair #(
   parameter int UNIFORM_BITS  = bmg_pkg::UNIFORM_BITS_DEF,
   parameter int OUT_FRAC_BITS = bmg_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  bmg_pkg::bmg_req_type req_data,
   output logic                 rsp_strobe,
   output bmg_pkg::bmg_rsp_type rsp_data
);
   import bmg_pkg::*;

   // radius path widths
   localparam int E_W     = $clog2(UNIFORM_BITS);
   localparam int T_W     = $clog2(UNIFORM_BITS + 1) + LOG_FRAC;
   localparam int R2_W    = T_W + 1;
   localparam int V_W     = R2_W + LOG_FRAC;
   localparam int RAD_W   = (V_W + 1) / 2;
   localparam int SQ_W    = 2 * RAD_W + 2;
   localparam int FB      = UNIFORM_BITS - 2;

   // stage indexes along the valid chain
   localparam int SQ_BASE = LOG_FRAC + 4;
   localparam int SQ_LAST = SQ_BASE + RAD_W - 1;
   localparam int MUL_IDX = SQ_BASE + RAD_W;
   localparam int LAT     = MUL_IDX + 2;
   localparam int ANG_LAT = 4 + 2 * HORNER_STEPS;
   localparam int DLY     = SQ_LAST - ANG_LAT;

   localparam int PROD_W  = RAD_W + TRIG_W;
   localparam int SH      = LOG_FRAC + 30 - OUT_FRAC_BITS;

   localparam logic [T_W-1:0] T_TOP = T_W'(UNIFORM_BITS) << LOG_FRAC;

   // control
   logic            busy_ff;
   logic [LAT-1:0]  vld_ff;
   logic            accept;

   assign accept = start & ~busy_ff;
   assign busy   = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         vld_ff  <= '0;
      end else begin
         busy_ff <= 1'b0;
         vld_ff  <= {vld_ff[LAT-2:0], accept};
      end
   end

   // input register, zero radius sample replaced by the smallest nonzero code
   logic [UNIFORM_BITS-1:0] k_raw, p_raw, in_k_in;
   logic [UNIFORM_BITS-1:0] in_k_ff, in_p_ff;

   if (UNIFORM_BITS <= FIELD_W) begin : g_in_narrow
      assign k_raw = req_data.uniform_radius[UNIFORM_BITS-1:0];
      assign p_raw = req_data.uniform_angle[UNIFORM_BITS-1:0];
   end else begin : g_in_wide
      assign k_raw = {{(UNIFORM_BITS-FIELD_W){1'b0}}, req_data.uniform_radius};
      assign p_raw = {{(UNIFORM_BITS-FIELD_W){1'b0}}, req_data.uniform_angle};
   end

   assign in_k_in = (k_raw == '0) ? UNIFORM_BITS'(1) : k_raw;

   always_ff @(posedge clock) begin
      in_k_ff <= in_k_in;
      in_p_ff <= p_raw;
   end

   // normalize: exponent of top set bit, mantissa in q1.30
   logic [E_W-1:0]            nrm_e_in, nrm_e_ff;
   logic [UNIFORM_BITS+29:0]  nrm_wide;
   logic [30:0]               nrm_m_in, nrm_m_ff;

   always_comb begin
      nrm_e_in = '0;
      for (int b = 0; b < UNIFORM_BITS; b++) begin
         if (in_k_ff[b]) begin
            nrm_e_in = E_W'(b);
         end
      end
   end

   assign nrm_wide = {in_k_ff, 30'b0} >> nrm_e_in;
   assign nrm_m_in = nrm_wide[30:0];

   always_ff @(posedge clock) begin
      nrm_e_ff <= nrm_e_in;
      nrm_m_ff <= nrm_m_in;
   end

   // log2 fraction: one squaring per stage, one result bit each
   logic [30:0]          log_m_ff [LOG_FRAC];
   logic [LOG_FRAC-1:0]  log_f_ff [LOG_FRAC];
   logic [E_W-1:0]       log_e_ff [LOG_FRAC];

   for (genvar g = 0; g < LOG_FRAC; g++) begin : g_log
      logic [30:0]         m_src;
      logic [LOG_FRAC-1:0] f_src;
      logic [E_W-1:0]      e_src;
      logic [61:0]         sq;
      logic [31:0]         sq_hi;

      if (g == 0) begin : g_first
         assign m_src = nrm_m_ff;
         assign f_src = '0;
         assign e_src = nrm_e_ff;
      end else begin : g_next
         assign m_src = log_m_ff[g-1];
         assign f_src = log_f_ff[g-1];
         assign e_src = log_e_ff[g-1];
      end

      assign sq    = 62'(m_src) * 62'(m_src);
      assign sq_hi = sq[61:30];

      always_ff @(posedge clock) begin
         log_m_ff[g] <= sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
         log_f_ff[g] <= {f_src[LOG_FRAC-2:0], sq_hi[31]};
         log_e_ff[g] <= e_src;
      end
   end

   // t = bits - log2(k), then -2 ln u1 = t * 2 ln 2
   logic [T_W-1:0]     t_in, t_ff;
   logic [T_W+30:0]    r2_prod;
   logic [R2_W-1:0]    r2_in, r2_ff;

   assign t_in    = T_TOP - T_W'({log_e_ff[LOG_FRAC-1], log_f_ff[LOG_FRAC-1]});
   assign r2_prod = (T_W+31)'(t_ff) * (T_W+31)'(TWO_LN2_Q30);
   assign r2_in   = r2_prod[30 +: R2_W];

   always_ff @(posedge clock) begin
      t_ff  <= t_in;
      r2_ff <= r2_in;
   end

   // square root, one result bit per stage
   logic [SQ_W-1:0]  rem_ff [RAD_W];
   logic [RAD_W-1:0] res_ff [RAD_W];

   for (genvar j = 0; j < RAD_W; j++) begin : g_sqrt
      localparam int I = RAD_W - 1 - j;
      logic [SQ_W-1:0]  rem_src, trial;
      logic [RAD_W-1:0] res_src;

      if (j == 0) begin : g_first
         assign rem_src = SQ_W'({r2_ff, {LOG_FRAC{1'b0}}});
         assign res_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign res_src = res_ff[j-1];
      end

      // (res + 2^i)^2 - res^2
      assign trial = (SQ_W'(res_src) << (I + 1)) + (SQ_W'(1) << (2 * I));

      always_ff @(posedge clock) begin
         if (trial <= rem_src) begin
            rem_ff[j] <= rem_src - trial;
            res_ff[j] <= res_src | (RAD_W'(1) << I);
         end else begin
            rem_ff[j] <= rem_src;
            res_ff[j] <= res_src;
         end
      end
   end

   // angle: quadrant and q30 fraction of a quarter turn, lane 0 sin, lane 1 cos
   logic [29:0]       ang_frac;
   logic [1:0]        a1_quad_ff, a2_quad_ff, a3_quad_ff;
   logic [TRIG_W-1:0] a1_q_ff [2];
   logic [TRIG_W-1:0] a2_x_ff [2];
   logic [TRIG_W-1:0] a3_x_ff [2];
   logic [X2_W-1:0]   a3_x2_ff [2];

   if (FB >= 30) begin : g_frac_cut
      assign ang_frac = in_p_ff[FB-1 -: 30];
   end else begin : g_frac_pad
      assign ang_frac = {in_p_ff[FB-1:0], {(30-FB){1'b0}}};
   end

   always_ff @(posedge clock) begin
      a1_quad_ff <= in_p_ff[UNIFORM_BITS-1 -: 2];
      a1_q_ff[0] <= {1'b0, ang_frac};
      a1_q_ff[1] <= Q30_ONE - {1'b0, ang_frac};
      a2_quad_ff <= a1_quad_ff;
      a3_quad_ff <= a2_quad_ff;
   end

   for (genvar l = 0; l < 2; l++) begin : g_ang
      logic [61:0] xp, x2p;

      assign xp  = 62'(a1_q_ff[l]) * 62'(HALF_PI_Q30);
      assign x2p = 62'(a2_x_ff[l]) * 62'(a2_x_ff[l]);

      always_ff @(posedge clock) begin
         a2_x_ff[l]  <= xp[60:30];
         a3_x_ff[l]  <= a2_x_ff[l];
         a3_x2_ff[l] <= x2p[61:30];
      end
   end

   // horner series: multiply stage then reciprocal-divide stage per term
   logic [TRIG_W-1:0] hx_ff    [2*HORNER_STEPS][2];
   logic [X2_W-1:0]   hx2_ff   [2*HORNER_STEPS][2];
   logic [X2_W-1:0]   hval_ff  [2*HORNER_STEPS][2];
   logic [1:0]        hquad_ff [2*HORNER_STEPS];

   for (genvar h = 0; h < HORNER_STEPS; h++) begin : g_horner
      localparam logic [RECIP_W-1:0] RECIP = horner_recip(h);
      localparam int                 SHIFT = horner_shift(h);

      if (h == 0) begin : g_first
         always_ff @(posedge clock) begin
            hquad_ff[0] <= a3_quad_ff;
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            hquad_ff[2*h] <= hquad_ff[2*h-1];
         end
      end

      always_ff @(posedge clock) begin
         hquad_ff[2*h+1] <= hquad_ff[2*h];
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [TRIG_W-1:0] acc, x_src;
         logic [X2_W-1:0]   x2_src;
         logic [62:0]       prod;
         logic [64:0]       quo;

         if (h == 0) begin : g_first
            assign acc    = Q30_ONE;
            assign x_src  = a3_x_ff[l];
            assign x2_src = a3_x2_ff[l];
         end else begin : g_next
            assign acc    = Q30_ONE - hval_ff[2*h-1][l][TRIG_W-1:0];
            assign x_src  = hx_ff[2*h-1][l];
            assign x2_src = hx2_ff[2*h-1][l];
         end

         assign prod = 63'(x2_src) * 63'(acc);
         assign quo  = 65'(hval_ff[2*h][l]) * 65'(RECIP);

         always_ff @(posedge clock) begin
            hval_ff[2*h][l]   <= prod[61:30];
            hx_ff[2*h][l]     <= x_src;
            hx2_ff[2*h][l]    <= x2_src;
            hval_ff[2*h+1][l] <= X2_W'(quo >> SHIFT);
            hx_ff[2*h+1][l]   <= hx_ff[2*h][l];
            hx2_ff[2*h+1][l]  <= hx2_ff[2*h][l];
         end
      end
   end

   // final sin term, then delay to meet the radius
   logic [TRIG_W-1:0] mag_ff [2];
   logic [1:0]        mag_quad_ff;
   logic [TRIG_W-1:0] dly_mag_ff  [DLY][2];
   logic [1:0]        dly_quad_ff [DLY];

   for (genvar l = 0; l < 2; l++) begin : g_mag
      logic [TRIG_W-1:0] acc;
      logic [61:0]       fp;

      assign acc = Q30_ONE - hval_ff[2*HORNER_STEPS-1][l][TRIG_W-1:0];
      assign fp  = 62'(hx_ff[2*HORNER_STEPS-1][l]) * 62'(acc);

      always_ff @(posedge clock) begin
         mag_ff[l] <= fp[60:30];
      end
   end

   always_ff @(posedge clock) begin
      mag_quad_ff <= hquad_ff[2*HORNER_STEPS-1];
   end

   for (genvar d = 0; d < DLY; d++) begin : g_dly
      if (d == 0) begin : g_first
         always_ff @(posedge clock) begin
            dly_mag_ff[0][0] <= mag_ff[0];
            dly_mag_ff[0][1] <= mag_ff[1];
            dly_quad_ff[0]   <= mag_quad_ff;
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            dly_mag_ff[d][0] <= dly_mag_ff[d-1][0];
            dly_mag_ff[d][1] <= dly_mag_ff[d-1][1];
            dly_quad_ff[d]   <= dly_quad_ff[d-1];
         end
      end
   end

   // quadrant fold: pick magnitude and sign per output, lane 0 cos, lane 1 sin
   logic [TRIG_W-1:0] sel_mag [2];
   logic              sel_neg [2];
   logic [PROD_W-1:0] mul_ff  [2];
   logic              neg_ff  [2];

   always_comb begin
      case (dly_quad_ff[DLY-1])
         QUAD_0: begin
            sel_mag[0] = dly_mag_ff[DLY-1][1];
            sel_neg[0] = 1'b0;
            sel_mag[1] = dly_mag_ff[DLY-1][0];
            sel_neg[1] = 1'b0;
         end
         QUAD_1: begin
            sel_mag[0] = dly_mag_ff[DLY-1][0];
            sel_neg[0] = 1'b1;
            sel_mag[1] = dly_mag_ff[DLY-1][1];
            sel_neg[1] = 1'b0;
         end
         QUAD_2: begin
            sel_mag[0] = dly_mag_ff[DLY-1][1];
            sel_neg[0] = 1'b1;
            sel_mag[1] = dly_mag_ff[DLY-1][0];
            sel_neg[1] = 1'b1;
         end
         default: begin
            sel_mag[0] = dly_mag_ff[DLY-1][0];
            sel_neg[0] = 1'b0;
            sel_mag[1] = dly_mag_ff[DLY-1][1];
            sel_neg[1] = 1'b1;
         end
      endcase
   end

   // radius times magnitude, then round half away, saturate and sign
   logic signed [OUT_W-1:0] out_ff [2];

   for (genvar l = 0; l < 2; l++) begin : g_out
      logic [PROD_W:0]      rnd;
      logic [PROD_W:0]      mag_r;
      logic [OUT_W-1:0]     out_in;

      assign rnd   = {1'b0, mul_ff[l]} + ((PROD_W+1)'(1) << (SH - 1));
      assign mag_r = rnd >> SH;

      always_comb begin
         if (neg_ff[l]) begin
            if (mag_r > (PROD_W+1)'(32768)) begin
               out_in = 16'h8000;
            end else begin
               out_in = OUT_W'(0) - mag_r[OUT_W-1:0];
            end
         end else begin
            if (mag_r > (PROD_W+1)'(32767)) begin
               out_in = 16'h7fff;
            end else begin
               out_in = mag_r[OUT_W-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         mul_ff[l] <= PROD_W'(res_ff[RAD_W-1]) * PROD_W'(sel_mag[l]);
         neg_ff[l] <= sel_neg[l];
         out_ff[l] <= out_in;
      end
   end

   assign rsp_strobe          = vld_ff[LAT-1];
   assign rsp_data.normal_cos = out_ff[0];
   assign rsp_data.normal_sin = out_ff[1];

   // checks
   a_radius_nonzero: assert property (@(posedge clock) disable iff (reset)
      vld_ff[SQ_LAST] |-> (res_ff[RAD_W-1] != '0))
      else $error("radius came out zero");

   a_cos_sign: assert property (@(posedge clock) disable iff (reset)
      vld_ff[MUL_IDX] |=> ($past(neg_ff[0]) || !rsp_data.normal_cos[OUT_W-1]))
      else $error("positive cos lane turned negative");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("result word right after reset");

endmodule
`default_nettype wire
